// ----- hdl/hrmg_pkg.sv -----
// Package with state type, register indexes, status codes and constants of the heart-rate gate.
package hrmg_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SORT,
    ST_EVAL,
    ST_STATUS,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    STAT_ABSENT = 2'd0,
    STAT_WARMUP = 2'd1,
    STAT_UNSTABLE = 2'd2,
    STAT_VALID = 2'd3
  } status_t;

  localparam logic [2:0] REG_THRESH = 3'd0;
  localparam logic [2:0] REG_SPREAD = 3'd1;
  localparam logic [2:0] REG_DELTA = 3'd2;
  localparam logic [2:0] REG_CONFIRM = 3'd3;
  localparam logic [2:0] REG_STALE = 3'd4;

  localparam logic [31:0] MIN_INTERVAL = 32'd236;
  localparam logic [31:0] MAX_INTERVAL = 32'd2999;
  localparam logic [15:0] MS_PER_MIN = 16'd60000;

endpackage

// ----- hdl/heart_rate_median_gate_top.sv -----
// Top level of the heart-rate median gate: sequencer, shared divider and window sorter.
//
//  Channel   Direction  Protocol  Contents
//  in_       slave      stream    tdata: ir_level[17:0], beat_seen[18], time_ms[50:19]
//  out_      master     stream    tdata: finger_on, status, heart_bpm, window_median, spread
//  cfg_      slave      APB       five registers at byte addresses 0, 4, 8, 12, 16
//
// A sample without an accepted beat goes from its transfer through the status state to the output state.
// An accepted beat adds the restoring divider, the load of the window and odd-even
// transposition sort through one shared compare-exchange row, and the evaluation state.
// Reset is synchronous; it clears control, configuration and window, not the data registers.
// in_tready is low from a transfer until its result has been taken.
module heart_rate_median_gate_top #(
  parameter int WINDOW_SIZE = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // ir_level[17:0], beat_seen[18], time_ms[50:19], zeros
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // finger_on[0], status[2:1], heart_bpm[10:3],
                                  // window_median[18:11], window_spread[26:19], zeros
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int SW = $clog2(WINDOW_SIZE);
  localparam int CW = $clog2(WINDOW_SIZE + 1);

  hrmg_pkg::state_t state_r, state_nxt;

  logic [17:0] thresh_r;
  logic [7:0]  spread_lim_r, delta_r;
  logic [3:0]  confirm_need_r;
  logic [15:0] stale_r;

  logic [7:0]    win_r [WINDOW_SIZE];
  logic [7:0]    srt_r [WINDOW_SIZE];
  logic [SW-1:0] slot_r;
  logic [CW-1:0] fill_r;
  logic [7:0]    median_r, spread_r, trusted_r, cand_r;
  logic          stable_r, trust_r, match_r, finger_r, have_prev_r;
  logic [3:0]    conf_r;
  logic [31:0]   prev_t_r, acc_t_r, now_r;
  logic          on_r;
  logic [15:0]   rem_r;
  logic [11:0]   div_r;
  logic [7:0]    quo_r;
  logic [4:0]    cnt_r;
  logic [31:0]   out_r;

  logic [17:0] in_ir;
  logic        in_beat;
  logic [31:0] in_time;
  assign in_ir = in_tdata[17:0];
  assign in_beat = in_tdata[18];
  assign in_time = in_tdata[50:19];

  logic in_fire, out_fire, cfg_wr;
  assign in_fire = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign in_tready = (state_r == hrmg_pkg::ST_IDLE);
  assign out_tvalid = (state_r == hrmg_pkg::ST_OUT);
  assign out_tdata = out_r;

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_paddr[4:2])
      hrmg_pkg::REG_THRESH: cfg_prdata = {14'd0, thresh_r};
      hrmg_pkg::REG_SPREAD: cfg_prdata = {24'd0, spread_lim_r};
      hrmg_pkg::REG_DELTA: cfg_prdata = {24'd0, delta_r};
      hrmg_pkg::REG_CONFIRM: cfg_prdata = {28'd0, confirm_need_r};
      hrmg_pkg::REG_STALE: cfg_prdata = {16'd0, stale_r};
      default: cfg_prdata = '0;
    endcase
  end

  // Interval checks for a beat accepted in this transfer, from the clean state if new contact.
  logic [31:0] interval;
  logic        have_prev_eff, acc_ok;
  assign have_prev_eff = finger_r && have_prev_r;
  assign interval = in_time - prev_t_r;
  assign acc_ok = have_prev_eff && in_beat && interval >= hrmg_pkg::MIN_INTERVAL &&
                  interval <= hrmg_pkg::MAX_INTERVAL;

  // Restoring divider step, one quotient bit per cycle.
  logic [3:0]  bit_idx;
  logic        div_bit;
  logic [16:0] trial;
  assign bit_idx = 4'd15 - cnt_r[3:0];
  assign div_bit = hrmg_pkg::MS_PER_MIN[bit_idx];
  assign trial = {rem_r, div_bit} - {5'd0, div_r};

  // Shared compare-exchange row for odd-even transposition sort.
  logic [7:0] row [WINDOW_SIZE];
  always_comb begin
    for (int i = 0; i < WINDOW_SIZE; i++) row[i] = srt_r[i];
    for (int i = 0; i + 1 < WINDOW_SIZE; i++) begin
      if ((i % 2) == int'(cnt_r[0]) && srt_r[i] > srt_r[i+1]) begin
        row[i] = srt_r[i+1];
        row[i+1] = srt_r[i];
      end
    end
  end

  logic [7:0] med_c, spr_c, dc, dt;
  logic [8:0] msum;
  assign msum = {1'b0, srt_r[WINDOW_SIZE/2-1]} + {1'b0, srt_r[WINDOW_SIZE/2]};
  assign med_c = msum[8:1];
  assign spr_c = srt_r[WINDOW_SIZE-1] - srt_r[0];
  assign dc = (med_c > cand_r) ? med_c - cand_r : cand_r - med_c;
  assign dt = (med_c > trusted_r) ? med_c - trusted_r : trusted_r - med_c;

  logic [31:0] age;
  assign age = now_r - acc_t_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hrmg_pkg::ST_IDLE: if (in_fire) begin
        state_nxt = acc_ok && (in_ir >= thresh_r) ? hrmg_pkg::ST_DIV : hrmg_pkg::ST_STATUS;
      end
      hrmg_pkg::ST_DIV: if (cnt_r == 5'd15) begin
        state_nxt = hrmg_pkg::ST_SORT;
      end
      hrmg_pkg::ST_SORT: if (32'(cnt_r) == 32'(WINDOW_SIZE)) begin
        state_nxt = hrmg_pkg::ST_EVAL;
      end
      hrmg_pkg::ST_EVAL: state_nxt = hrmg_pkg::ST_STATUS;
      hrmg_pkg::ST_STATUS: state_nxt = hrmg_pkg::ST_OUT;
      hrmg_pkg::ST_OUT: if (out_fire) begin
        state_nxt = hrmg_pkg::ST_IDLE;
      end
      default: state_nxt = hrmg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hrmg_pkg::ST_IDLE;
      thresh_r <= 18'd50000;
      spread_lim_r <= 8'd18;
      delta_r <= 8'd8;
      confirm_need_r <= 4'd2;
      stale_r <= 16'd5000;
      for (int i = 0; i < WINDOW_SIZE; i++) win_r[i] <= '0;
      slot_r <= '0;
      fill_r <= '0;
      median_r <= '0;
      spread_r <= '0;
      stable_r <= 1'b0;
      trusted_r <= '0;
      trust_r <= 1'b0;
      match_r <= 1'b0;
      cand_r <= '0;
      conf_r <= '0;
      finger_r <= 1'b0;
      have_prev_r <= 1'b0;
      prev_t_r <= '0;
      acc_t_r <= '0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        unique case (cfg_paddr[4:2])
          hrmg_pkg::REG_THRESH: thresh_r <= cfg_pwdata[17:0];
          hrmg_pkg::REG_SPREAD: spread_lim_r <= cfg_pwdata[7:0];
          hrmg_pkg::REG_DELTA: delta_r <= cfg_pwdata[7:0];
          hrmg_pkg::REG_CONFIRM: confirm_need_r <= cfg_pwdata[3:0];
          hrmg_pkg::REG_STALE: stale_r <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
      unique case (state_r)
        hrmg_pkg::ST_IDLE: if (in_fire) begin
          now_r <= in_time;
          on_r <= (in_ir >= thresh_r);
          rem_r <= '0;
          div_r <= interval[11:0];
          cnt_r <= '0;
          if ((in_ir >= thresh_r) != finger_r || !(in_ir >= thresh_r)) begin
            if (finger_r || (in_ir >= thresh_r)) begin
              for (int i = 0; i < WINDOW_SIZE; i++) win_r[i] <= '0;
              slot_r <= '0;
              fill_r <= '0;
              median_r <= '0;
              spread_r <= '0;
              stable_r <= 1'b0;
              trusted_r <= '0;
              trust_r <= 1'b0;
              match_r <= 1'b0;
              cand_r <= '0;
              conf_r <= '0;
              acc_t_r <= '0;
              have_prev_r <= 1'b0;
              prev_t_r <= '0;
            end
          end
          finger_r <= (in_ir >= thresh_r);
          if ((in_ir >= thresh_r) && in_beat) begin
            have_prev_r <= 1'b1;
            prev_t_r <= in_time;
          end
        end
        hrmg_pkg::ST_DIV: begin
          if (!trial[16]) begin
            rem_r <= trial[15:0];
            quo_r <= {quo_r[6:0], 1'b1};
          end else begin
            rem_r <= {rem_r[14:0], div_bit};
            quo_r <= {quo_r[6:0], 1'b0};
          end
          cnt_r <= (cnt_r == 5'd15) ? 5'd0 : cnt_r + 5'd1;
        end
        hrmg_pkg::ST_SORT: begin
          if (cnt_r == '0) begin
            for (int i = 0; i < WINDOW_SIZE; i++) begin
              srt_r[i] <= (i == int'(slot_r)) ? quo_r : win_r[i];
            end
            win_r[slot_r] <= quo_r;
            slot_r <= (32'(slot_r) == 32'(WINDOW_SIZE - 1)) ? '0 : slot_r + SW'(1);
            if (32'(fill_r) < 32'(WINDOW_SIZE)) fill_r <= fill_r + CW'(1);
            acc_t_r <= now_r;
          end else begin
            for (int i = 0; i < WINDOW_SIZE; i++) srt_r[i] <= row[i];
          end
          cnt_r <= cnt_r + 5'd1;
        end
        hrmg_pkg::ST_EVAL: begin
          match_r <= 1'b0;
          if (32'(fill_r) < 32'(WINDOW_SIZE)) begin
            stable_r <= 1'b0;
          end else begin
            median_r <= med_c;
            spread_r <= spr_c;
            stable_r <= (spr_c <= spread_lim_r);
            if (spr_c <= spread_lim_r) begin
              if (!trust_r) begin
                if (conf_r == '0 || dc > delta_r) begin
                  cand_r <= med_c;
                  conf_r <= 4'd1;
                end else begin
                  if (conf_r < 4'd15) conf_r <= conf_r + 4'd1;
                  if (((conf_r < 4'd15) ? conf_r + 4'd1 : conf_r) >= confirm_need_r) begin
                    trusted_r <= med_c;
                    trust_r <= 1'b1;
                    match_r <= 1'b1;
                  end
                end
              end else if (dt <= delta_r) begin
                trusted_r <= med_c;
                match_r <= 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result word is built once all state of this transfer has settled.
  always_ff @(posedge clk) begin
    if (state_r == hrmg_pkg::ST_STATUS) begin
      out_r <= '0;
      out_r[0] <= on_r;
      out_r[18:11] <= median_r;
      out_r[26:19] <= spread_r;
      if (!on_r) begin
        out_r[2:1] <= hrmg_pkg::STAT_ABSENT;
      end else if (32'(fill_r) < 32'(WINDOW_SIZE) || !trust_r) begin
        out_r[2:1] <= hrmg_pkg::STAT_WARMUP;
      end else if (age >= {16'd0, stale_r} || !stable_r || !match_r) begin
        out_r[2:1] <= hrmg_pkg::STAT_UNSTABLE;
      end else begin
        out_r[2:1] <= hrmg_pkg::STAT_VALID;
        out_r[10:3] <= trusted_r;
      end
    end
  end

  a_ready_out: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("ready while result pending");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_valid_bpm: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:1] != hrmg_pkg::STAT_VALID |-> out_tdata[10:3] == 8'd0)
    else $error("bpm shown without valid status");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= 32'(WINDOW_SIZE)) else $error("fill count overflow");

endmodule
